>>> hdl/fmr_pkg.sv
// Shared types, constants and the frame length table of the framed message receiver.
`timescale 1ns / 1ps

package fmr_pkg;

    localparam int TEXT_LEN      = 9;
    localparam int PAYLOAD_DEPTH = 9;
    localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);
    localparam int CNT_W         = 4;
    localparam int TDATA_IN_W    = 8;
    localparam int RESULT_W      = 126;
    localparam int TDATA_OUT_W   = 128;

    localparam logic [7:0] GOOD_SUM = 8'hFF;
    localparam logic [7:0] MAX_TYPE = 8'd8;

    typedef enum logic [1:0] {
        STATUS_GOOD     = 2'd0,
        STATUS_BAD_SUM  = 2'd1,
        STATUS_UNKNOWN  = 2'd2
    } frame_status_t;

    // Declared from the top field down so that frame_type lands in the lowest bits.
    typedef struct packed {
        logic [3:0]    frame_length;
        logic [63:0]   payload_tail;
        logic [7:0]    payload_head;
        logic [7:0]    result_value;
        logic [15:0]   second_word;
        logic [15:0]   first_word;
        frame_status_t frame_status;
        logic [7:0]    frame_type;
    } frame_result_t;

    // Frame length, type and checksum bytes included, for a known type byte.
    function automatic logic [CNT_W-1:0] frame_len_of(input logic [7:0] type_byte);
        logic [CNT_W-1:0] len;
        unique case (type_byte[3:0])
            4'd5:    len = CNT_W'(5);
            4'd6:    len = CNT_W'(2 + TEXT_LEN);
            4'd7:    len = CNT_W'(6);
            4'd8:    len = CNT_W'(7);
            default: len = CNT_W'(2);
        endcase
        return len;
    endfunction

endpackage

>>> hdl/framed_message_receiver_top.sv
// Top level of the framed message receiver: byte stream in, frame results out.
//
//  Channel  | Dir | Handshake          | Data
//  ---------+-----+--------------------+-----------------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[7:0] rx_byte
//  m_       | out | m_tvalid/m_tready  | m_tdata[125:0] frame result, zero padded
//
// One byte is taken per cycle while s_tready is high, and each result is registered.
// The frame state and checksum update in combinational logic between the state
// registers and the result register, and a skid stage keeps s_tready high while
// one result waits. s_tready drops only when two results are held back by m_tready.
// aresetn (synchronous) returns the receiver to waiting for a type byte.
`timescale 1ns / 1ps

module framed_message_receiver_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fmr_pkg::TDATA_IN_W-1:0]   s_tdata,  // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] frame_type, [9:8] frame_status, [25:10] first_word, [41:26] second_word,
    // [49:42] result_value, [57:50] payload_head, [121:58] payload_tail,
    // [125:122] frame_length, [127:126] zero
    output logic [fmr_pkg::TDATA_OUT_W-1:0]  m_tdata
);
    import fmr_pkg::*;

    logic          byte_accept;
    logic          res_valid;
    frame_result_t res;
    frame_result_t out_res;

    assign byte_accept = s_tvalid && s_tready;

    fmr_collector u_collector (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .byte_valid (byte_accept),
        .rx_byte    (s_tdata),
        .res_valid  (res_valid),
        .res        (res)
    );

    fmr_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    assign m_tdata = {(TDATA_OUT_W - RESULT_W)'(0), out_res};

endmodule

>>> hdl/fmr_collector.sv
// Frame state, running checksum, payload capture; one result per frame or unknown type byte.
`timescale 1ns / 1ps

module fmr_collector (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  byte_valid,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output fmr_pkg::frame_result_t res
);
    import fmr_pkg::*;

    logic                  in_frame_reg, in_frame_next;
    logic [3:0]            cur_type_reg, cur_type_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CNT_W-1:0]      exp_len_reg, exp_len_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            payload_reg [PAYLOAD_DEPTH];
    logic [7:0]            payload_next [PAYLOAD_DEPTH];
    logic                  known;
    logic                  store_ok;
    logic [CNT_W:0]        seen_plus1;

    assign known      = (rx_byte <= MAX_TYPE);
    assign seen_plus1 = {1'b0, seen_reg} + (CNT_W+1)'(1);
    assign store_ok   = (seen_plus1 < {1'b0, exp_len_reg}) &&
                        (seen_reg <= CNT_W'(PAYLOAD_DEPTH));

    always_comb begin
        in_frame_next = in_frame_reg;
        cur_type_next = cur_type_reg;
        seen_next     = seen_reg;
        exp_len_next  = exp_len_reg;
        sum_next      = sum_reg;
        for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
            payload_next[i] = payload_reg[i];
        end
        res_valid = 1'b0;
        res       = '0;

        if (byte_valid) begin
            if (!in_frame_reg) begin
                if (!known) begin
                    // An unknown type byte is reported at once as a one-byte frame.
                    res_valid        = 1'b1;
                    res.frame_type   = rx_byte;
                    res.frame_status = STATUS_UNKNOWN;
                    res.frame_length = CNT_W'(1);
                end else begin
                    in_frame_next = 1'b1;
                    cur_type_next = rx_byte[3:0];
                    seen_next     = CNT_W'(1);
                    exp_len_next  = frame_len_of(rx_byte);
                    sum_next      = rx_byte;
                    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
                        payload_next[i] = '0;
                    end
                end
            end else begin
                sum_next  = sum_reg + rx_byte;
                seen_next = seen_plus1[CNT_W-1:0];
                for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
                    if (store_ok && seen_reg == CNT_W'(i + 1)) begin
                        payload_next[i] = rx_byte;
                    end
                end
                // The checksum byte is never stored, so the payload registers are final here.
                if (seen_plus1[CNT_W-1:0] >= exp_len_reg) begin
                    res_valid        = 1'b1;
                    res.frame_type   = {4'd0, cur_type_reg};
                    res.frame_status = (sum_next == GOOD_SUM) ? STATUS_GOOD : STATUS_BAD_SUM;
                    res.first_word   = {payload_reg[0], payload_reg[1]};
                    res.second_word  = {payload_reg[2], payload_reg[3]};
                    res.result_value = payload_reg[4];
                    res.payload_head = payload_reg[0];
                    res.payload_tail = {payload_reg[1], payload_reg[2], payload_reg[3],
                                        payload_reg[4], payload_reg[5], payload_reg[6],
                                        payload_reg[7], payload_reg[8]};
                    res.frame_length = exp_len_reg;
                    in_frame_next    = 1'b0;
                    seen_next        = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            cur_type_reg <= '0;
            seen_reg     <= '0;
            exp_len_reg  <= '0;
            sum_reg      <= '0;
            for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
                payload_reg[i] <= '0;
            end
        end else begin
            in_frame_reg <= in_frame_next;
            cur_type_reg <= cur_type_next;
            seen_reg     <= seen_next;
            exp_len_reg  <= exp_len_next;
            sum_reg      <= sum_next;
            for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
                payload_reg[i] <= payload_next[i];
            end
        end
    end

endmodule

>>> hdl/fmr_out_reg.sv
// Result register with a skid stage so the input side keeps running while a result waits.
`timescale 1ns / 1ps

module fmr_out_reg (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fmr_pkg::frame_result_t push_data,
    output logic                  can_accept,
    output logic                  out_valid,
    input  logic                  out_ready,
    output fmr_pkg::frame_result_t out_data
);
    import fmr_pkg::*;

    logic          main_valid_reg, main_valid_next;
    logic          skid_valid_reg, skid_valid_next;
    frame_result_t main_reg, main_next;
    frame_result_t skid_reg, skid_next;
    logic          pop;

    assign pop        = main_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg) begin
            // Input side is held off; drain the skid word into the output register.
            if (pop) begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (pop || !main_valid_reg) begin
            main_valid_next = push;
            main_next       = push_data;
        end else if (push) begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the framed message receiver: directed table, then random frames.
`timescale 1ns / 1ps

module testbench;
    import fmr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1550;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned HOLD_START   = 400;
    localparam int unsigned HOLD_CYCLES  = 80;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        frame_result_t res;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;

    // Receiver model state, advanced once per accepted word.
    logic       rx_in_frame;
    logic [3:0] rx_type;
    logic [3:0] rx_seen;
    logic [3:0] rx_len;
    logic [7:0] rx_sum;
    logic [7:0] rx_payload [PAYLOAD_DEPTH];

    frame_result_t frame_q [$];
    stim_row_t     dir_rows [24];

    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned sent_items;
    int unsigned good_frames;
    int unsigned bad_frames;
    int unsigned unknown_bytes;
    bit          tx_gaps_on;

    framed_message_receiver_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL framed_message_receiver_top");
            $finish;
        end
    end

    // Frame length with type and checksum bytes; zero marks a type byte with no entry.
    function automatic logic [3:0] frame_len_for(input logic [7:0] b);
        logic [3:0] len;
        case (b) inside
            [8'd0:8'd4]: len = 4'd2;
            8'd5:        len = 4'd5;
            8'd6:        len = 4'(2 + TEXT_LEN);
            8'd7:        len = 4'd6;
            8'd8:        len = 4'd7;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

    // Advances the receiver state by one word; returns 1 when a frame result is due.
    function automatic bit frame_step(input logic [7:0] b, output frame_result_t r);
        logic [3:0]  len;
        logic [63:0] tail;
        int          i;
        r = '0;
        if (!rx_in_frame) begin
            len = frame_len_for(b);
            if (len == 4'd0) begin
                r.frame_type   = b;
                r.frame_status = STATUS_UNKNOWN;
                r.frame_length = 4'd1;
                return 1'b1;
            end
            rx_in_frame = 1'b1;
            rx_type     = b[3:0];
            rx_seen     = 4'd1;
            rx_len      = len;
            rx_sum      = b;
            for (i = 0; i < PAYLOAD_DEPTH; i++) rx_payload[i] = 8'h00;
            return 1'b0;
        end
        rx_sum = rx_sum + b;
        // The checksum byte is summed but never stored as payload.
        if (rx_seen + 1 < rx_len && rx_seen <= PAYLOAD_DEPTH) rx_payload[rx_seen - 4'd1] = b;
        rx_seen = rx_seen + 4'd1;
        if (rx_seen < rx_len) return 1'b0;
        tail = '0;
        for (i = 1; i < PAYLOAD_DEPTH; i++) tail = {tail[55:0], rx_payload[i]};
        r.frame_type   = {4'h0, rx_type};
        r.frame_status = (rx_sum == GOOD_SUM) ? STATUS_GOOD : STATUS_BAD_SUM;
        r.first_word   = {rx_payload[0], rx_payload[1]};
        r.second_word  = {rx_payload[2], rx_payload[3]};
        r.result_value = rx_payload[4];
        r.payload_head = rx_payload[0];
        r.payload_tail = tail;
        r.frame_length = rx_len;
        rx_in_frame = 1'b0;
        rx_seen     = 4'd0;
        return 1'b1;
    endfunction

    function automatic stim_row_t mk_row(input logic [7:0] rx, input logic typed,
                                         input logic [7:0] ftype, input frame_status_t st,
                                         input logic [3:0] len);
        stim_row_t row;
        row                  = '0;
        row.rx               = rx;
        row.typed            = typed;
        row.res.frame_type   = ftype;
        row.res.frame_status = st;
        row.res.frame_length = len;
        return row;
    endfunction

    // Offers one word at the falling edge and waits for it to be taken.
    task automatic send_word(input logic [7:0] b, input logic use_typed,
                             input frame_result_t typed_res);
        frame_result_t pred;
        while (tx_gaps_on && $urandom_range(99) < 24) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (frame_step(b, pred)) frame_q.push_back(use_typed ? typed_res : pred);
        sent_items++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Mostly well-formed frames with random payload; the rest are bad sums and stray bytes.
    task automatic send_random_frame();
        logic [7:0] t;
        logic [7:0] p;
        logic [7:0] sum;
        logic [3:0] len;
        int         i;
        if ($urandom_range(99) < 10) begin
            send_word(8'($urandom_range(255, 9)), 1'b0, '0);
            return;
        end
        t   = 8'($urandom_range(8));
        len = frame_len_for(t);
        sum = t;
        send_word(t, 1'b0, '0);
        for (i = 1; i < len - 1; i++) begin
            p   = 8'($urandom_range(255));
            sum = sum + p;
            send_word(p, 1'b0, '0);
        end
        if ($urandom_range(99) < 75) send_word(GOOD_SUM - sum, 1'b0, '0);
        else send_word(8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = frame_result_t'(m_tdata[RESULT_W-1:0]);
            if (frame_q.size() == 0) begin
                $error("unexpected frame result 0x%0h", got);
                mismatches++;
            end else begin
                want = frame_q.pop_front();
                check_field("frame_type", 64'(want.frame_type), 64'(got.frame_type));
                check_field("frame_status", 64'(want.frame_status), 64'(got.frame_status));
                check_field("first_word", 64'(want.first_word), 64'(got.first_word));
                check_field("second_word", 64'(want.second_word), 64'(got.second_word));
                check_field("result_value", 64'(want.result_value), 64'(got.result_value));
                check_field("payload_head", 64'(want.payload_head), 64'(got.payload_head));
                check_field("payload_tail", want.payload_tail, got.payload_tail);
                check_field("frame_length", 64'(want.frame_length), 64'(got.frame_length));
                case (want.frame_status)
                    STATUS_GOOD:    good_frames++;
                    STATUS_BAD_SUM: bad_frames++;
                    default:        unknown_bytes++;
                endcase
            end
        end
    end

    // Result side: random stalls, one long hold-off that backs the block up, and a calm stretch.
    initial begin : result_sink
        int unsigned sink_cycle;
        sink_cycle = 0;
        m_tready   = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            sink_cycle++;
            if (sink_cycle == HOLD_START) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                sink_cycle += HOLD_CYCLES;
            end
            if (sink_cycle >= 1200 && sink_cycle < 1800) m_tready = 1'b1;
            else m_tready = ($urandom_range(99) >= 24);
        end
    end

    initial begin : stimulus
        int unsigned random_start;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cycle_count   = 0;
        mismatches    = 0;
        sent_items    = 0;
        good_frames   = 0;
        bad_frames    = 0;
        unknown_bytes = 0;
        tx_gaps_on    = 1'b1;
        rx_in_frame   = 1'b0;
        rx_type       = '0;
        rx_seen       = '0;
        rx_len        = '0;
        rx_sum        = '0;
        for (int i = 0; i < PAYLOAD_DEPTH; i++) rx_payload[i] = 8'h00;

        // Stray type bytes, including one whose low nibble looks like a known type.
        dir_rows[0]  = mk_row(8'hFF, 1'b1, 8'hFF, STATUS_UNKNOWN, 4'd1);
        dir_rows[1]  = mk_row(8'h09, 1'b1, 8'h09, STATUS_UNKNOWN, 4'd1);
        dir_rows[2]  = mk_row(8'h10, 1'b1, 8'h10, STATUS_UNKNOWN, 4'd1);
        // Short frames without payload: one good, one with a bad sum.
        dir_rows[3]  = mk_row(8'h00, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[4]  = mk_row(8'hFF, 1'b1, 8'h00, STATUS_GOOD, 4'd2);
        dir_rows[5]  = mk_row(8'h04, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[6]  = mk_row(8'h00, 1'b1, 8'h04, STATUS_BAD_SUM, 4'd2);
        // Longest frame, payload at the byte extremes.
        dir_rows[7]  = mk_row(8'h06, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[8]  = mk_row(8'h00, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[9]  = mk_row(8'hFF, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[10] = mk_row(8'h80, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[11] = mk_row(8'h01, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[12] = mk_row(8'h7F, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[13] = mk_row(8'hAA, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[14] = mk_row(8'h55, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[15] = mk_row(8'hFE, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[16] = mk_row(8'h01, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[17] = mk_row(8'hFC, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        // Type 5 frame of three payload bytes with a good sum, then a stray byte.
        dir_rows[18] = mk_row(8'h05, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[19] = mk_row(8'h12, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[20] = mk_row(8'h34, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[21] = mk_row(8'h56, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[22] = mk_row(8'h5E, 1'b0, 8'h00, STATUS_GOOD, 4'd0);
        dir_rows[23] = mk_row(8'h80, 1'b1, 8'h80, STATUS_UNKNOWN, 4'd1);

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[i]) send_word(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

        random_start = sent_items;
        while (sent_items - random_start < RANDOM_ITEMS) begin
            tx_gaps_on = !(sent_items - random_start >= 700 && sent_items - random_start < 1000);
            send_random_frame();
        end

        while (frame_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d words; checked %0d good frames, %0d bad-sum frames, %0d stray bytes.",
                 sent_items, good_frames, bad_frames, unknown_bytes);
        $display("Random stalls on both sides plus one long result hold-off were exercised.");
        if (mismatches == 0) begin
            $display("PASS framed_message_receiver_top");
        end else begin
            $display("FAIL framed_message_receiver_top");
        end
        $finish;
    end

endmodule
